// File: design/erstep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the euclidean rhythm step generator.
// No dependencies; used by erstep_ctrl, erstep_datapath and the top level.
package erstep_pkg;

    // Field widths fixed by the register map and the result format
    localparam int CFG_W = 7;
    localparam int POS_W = 6;
    localparam int IDX_W = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_STEPS    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DENSITY  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ROTATION = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] STEPS_RESET    = 7'd16;
    localparam logic [CFG_W-1:0] DENSITY_RESET  = 7'd0;
    localparam logic [CFG_W-1:0] ROTATION_RESET = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MERGE,
        ST_HEADS,
        ST_TAILS
    } t_state;

    typedef struct packed {
        logic cfg_we;
        logic init;
        logic merge;
        logic app_head;
        logic app_tail;
        logic tick_take;
        logic out_take;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic merge_more;
        logic nh_zero;
        logic nt_zero;
    } t_dp_status;

endpackage

// File: design/erstep_ctrl.sv
`timescale 1ns / 1ps
// Control state machine: handshakes and the pattern build sequence.
// Depends on erstep_pkg; drives erstep_datapath through t_dp_cmd.
module erstep_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_tick,
    output logic                             o_stall,
    input  logic                             i_stall,
    input  logic                             i_cfg_valid,
    input  logic [erstep_pkg::IDX_W-1:0]     i_cfg_index,
    output logic                             o_cfg_ready,
    input  erstep_pkg::t_dp_status           i_status,
    output erstep_pkg::t_dp_cmd              o_cmd
);

    erstep_pkg::t_state r_state;
    erstep_pkg::t_state n_state;
    logic               w_idle;
    logic               w_stall;
    logic               w_build_start;

    assign w_idle        = (r_state == erstep_pkg::ST_IDLE);
    assign w_stall       = !w_idle || (i_status.out_valid && i_stall);
    assign w_build_start = i_cfg_valid && w_idle &&
                           ((i_cfg_index == erstep_pkg::CFG_STEPS) ||
                            (i_cfg_index == erstep_pkg::CFG_DENSITY));

    always_comb begin
        n_state = r_state;
        case (r_state)
            erstep_pkg::ST_IDLE: begin
                if (w_build_start) begin
                    n_state = erstep_pkg::ST_INIT;
                end
            end
            erstep_pkg::ST_INIT: begin
                n_state = erstep_pkg::ST_MERGE;
            end
            erstep_pkg::ST_MERGE: begin
                if (!i_status.merge_more) begin
                    n_state = erstep_pkg::ST_HEADS;
                end
            end
            erstep_pkg::ST_HEADS: begin
                if (i_status.nh_zero) begin
                    n_state = erstep_pkg::ST_TAILS;
                end
            end
            erstep_pkg::ST_TAILS: begin
                if (i_status.nt_zero) begin
                    n_state = erstep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = erstep_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.cfg_we    = i_cfg_valid && w_idle;
        o_cmd.tick_take = i_valid && !w_stall && i_tick;
        o_cmd.out_take  = i_status.out_valid && !i_stall;
        case (r_state)
            erstep_pkg::ST_INIT:  o_cmd.init     = 1'b1;
            erstep_pkg::ST_MERGE: o_cmd.merge    = i_status.merge_more;
            erstep_pkg::ST_HEADS: o_cmd.app_head = !i_status.nh_zero;
            erstep_pkg::ST_TAILS: o_cmd.app_tail = !i_status.nt_zero;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erstep_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall     = w_stall;
    assign o_cfg_ready = w_idle;

    // Leaving the build, both the head and the tail copies must be used up
    a_build_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_idle && ($past(r_state) == erstep_pkg::ST_TAILS)) |->
            (i_status.nh_zero && i_status.nt_zero))
        else $error("build finished with copies left");

    // A build is only ever started by a steps or density transfer
    a_build_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == erstep_pkg::ST_INIT) |->
            ($past(w_idle) && $past(i_cfg_valid)))
        else $error("build started without a config transfer");

endmodule

// File: design/erstep_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, Bjorklund merge/append unit, pattern,
// step counter and output register. Depends on erstep_pkg.
module erstep_datapath #(
    parameter int MAX_STEPS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  erstep_pkg::t_dp_cmd               i_cmd,
    input  logic [erstep_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [erstep_pkg::CFG_W-1:0]      i_cfg_data,
    output erstep_pkg::t_dp_status            o_status,
    output logic                              o_pulse,
    output logic [erstep_pkg::POS_W-1:0]      o_step_position
);

    localparam int CW  = erstep_pkg::CFG_W;
    localparam int PW  = erstep_pkg::POS_W;
    localparam int PIW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_STEPS);

    logic [CW-1:0]        r_steps, r_density, r_rotation;
    logic [PW-1:0]        r_counter, n_counter;
    logic [MAX_STEPS-1:0] r_pattern, n_pattern;
    logic [MAX_STEPS-1:0] r_hb, n_hb, r_tb, n_tb;
    logic [CW-1:0]        r_hl, n_hl, r_tl, n_tl;
    logic [CW-1:0]        r_nh, n_nh, r_nt, n_nt;
    logic [CW-1:0]        r_len, n_len;
    logic                 r_out_valid;
    logic                 r_pulse;
    logic [PW-1:0]        r_pos;

    logic [CW-1:0]        w_n, w_k, w_rot;
    logic [CW-1:0]        w_sum, w_pos, w_cnt_inc;
    logic [MAX_STEPS-1:0] w_merged;
    logic                 w_steps_we;

    // Effective cycle length and saturated density/rotation
    always_comb begin
        w_n = r_steps;
        if (r_steps == '0) begin
            w_n = CW'(1);
        end else if (r_steps > MAX_N) begin
            w_n = MAX_N;
        end
        w_k   = (r_density  > w_n) ? w_n : r_density;
        w_rot = (r_rotation > w_n) ? w_n : r_rotation;
    end

    // Read position: both terms stay below 2n, so one subtract wraps it
    assign w_sum     = w_rot + CW'(r_counter);
    assign w_pos     = (w_sum >= w_n) ? (w_sum - w_n) : w_sum;
    assign w_cnt_inc = CW'(r_counter) + CW'(1);
    assign w_merged  = r_hb | (r_tb << r_hl);
    assign w_steps_we = i_cmd.cfg_we && (i_cfg_index == erstep_pkg::CFG_STEPS);

    always_comb begin
        n_counter = r_counter;
        if (w_steps_we) begin
            n_counter = '0;
        end else if (i_cmd.tick_take) begin
            n_counter = (w_cnt_inc >= w_n) ? '0 : w_cnt_inc[PW-1:0];
        end
    end

    always_comb begin
        n_pattern = r_pattern;
        n_len     = r_len;
        n_hb      = r_hb;
        n_tb      = r_tb;
        n_hl      = r_hl;
        n_tl      = r_tl;
        n_nh      = r_nh;
        n_nt      = r_nt;
        if (i_cmd.init) begin
            n_pattern = '0;
            n_len     = '0;
            n_hb      = MAX_STEPS'(1);
            n_tb      = '0;
            n_hl      = CW'(1);
            n_tl      = CW'(1);
            n_nh      = w_k;
            n_nt      = w_n - w_k;
        end else if (i_cmd.merge) begin
            n_hb = w_merged;
            n_hl = r_hl + r_tl;
            if (r_nh < r_nt) begin
                n_nt = r_nt - r_nh;
            end else begin
                n_tb = r_hb;
                n_tl = r_hl;
                n_nh = r_nt;
                n_nt = r_nh - r_nt;
            end
        end else if (i_cmd.app_head) begin
            n_pattern = r_pattern | (r_hb << r_len);
            n_len     = r_len + r_hl;
            n_nh      = r_nh - CW'(1);
        end else if (i_cmd.app_tail) begin
            n_pattern = r_pattern | (r_tb << r_len);
            n_len     = r_len + r_tl;
            n_nt      = r_nt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= erstep_pkg::STEPS_RESET;
            r_density   <= erstep_pkg::DENSITY_RESET;
            r_rotation  <= erstep_pkg::ROTATION_RESET;
            r_counter   <= '0;
            r_pattern   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                case (i_cfg_index)
                    erstep_pkg::CFG_STEPS:    r_steps    <= i_cfg_data;
                    erstep_pkg::CFG_DENSITY:  r_density  <= i_cfg_data;
                    erstep_pkg::CFG_ROTATION: r_rotation <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_counter <= n_counter;
            r_pattern <= n_pattern;
            if (i_cmd.tick_take) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_hb  <= n_hb;
        r_tb  <= n_tb;
        r_hl  <= n_hl;
        r_tl  <= n_tl;
        r_nh  <= n_nh;
        r_nt  <= n_nt;
        if (i_cmd.tick_take) begin
            r_pulse <= r_pattern[w_pos[PIW-1:0]];
            r_pos   <= w_pos[PW-1:0];
        end
    end

    assign o_status.out_valid  = r_out_valid;
    assign o_status.merge_more = (r_nt > CW'(1)) && (r_nh != '0);
    assign o_status.nh_zero    = (r_nh == '0);
    assign o_status.nt_zero    = (r_nt == '0);
    assign o_pulse             = r_pulse;
    assign o_step_position     = r_pos;

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_counter) < w_n))
        else $error("step counter beyond cycle length");

    a_head_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_head |-> ((8'(r_len) + 8'(r_hl)) <= 8'(w_n)))
        else $error("head copy overruns the cycle");

    a_tail_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_tail |-> ((8'(r_len) + 8'(r_tl)) <= 8'(w_n)))
        else $error("tail copy overruns the cycle");

endmodule

// File: design/euclidean_rhythm_step_generator.sv
`timescale 1ns / 1ps
// Euclidean rhythm step generator: a cycle of 'steps' steps carrying 'density'
// pulses spread by the Bjorklund recursion. Each transfer with i_tick high
// returns one result: whether the step at (rotation + counter) mod steps holds
// a pulse, and that step index; the counter then advances and wraps at steps.
// A transfer with i_tick low is taken and dropped. A tick's result is
// registered into the output register at the edge that takes the tick; the
// next tick may enter in the same cycle that the pending result is taken, so
// ticks flow at one per cycle while the downstream side keeps up and no
// rebuild is running. Writing steps or density rebuilds the pattern in the
// datapath's merge/append unit: it loads, runs the merges of the recursion,
// appends the head copies, then the tail copies, and closes each of the
// merge, head and tail phases in a step of its own. Merges and copies
// together never exceed the effective steps. During the rebuild o_stall is
// high and o_cfg_ready is low. Writing steps also returns the counter to
// zero. Steps of zero act as one, steps above MAX_STEPS act as MAX_STEPS;
// density and rotation saturate to the effective steps, and rotation equal
// to steps acts as zero. Write registers only while no tick result is
// outstanding. Depends on erstep_pkg, erstep_ctrl and erstep_datapath.
module euclidean_rhythm_step_generator #(
    parameter int MAX_STEPS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Tick input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_tick,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_pulse,
    output logic [erstep_pkg::POS_W-1:0]     o_step_position,
    // Register write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [erstep_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [erstep_pkg::CFG_W-1:0]     i_cfg_data
);

    erstep_pkg::t_dp_cmd    w_cmd;
    erstep_pkg::t_dp_status w_status;

    // Sequencer: handshakes plus the rebuild order (load, merge, heads, tails)
    erstep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_tick      (i_tick),
        .o_stall     (o_stall),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Registers, pattern builder, step counter and the output register
    erstep_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (w_status),
        .o_pulse         (o_pulse),
        .o_step_position (o_step_position)
    );

    // Result valid comes straight from the output register
    assign o_valid = w_status.out_valid;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for euclidean_rhythm_step_generator: ticks and register
// writes go in, every result transfer is checked against an in-bench Bjorklund model.
// Depends on erstep_pkg and the design sources of the block.
module tb;

    localparam int MAX_STEPS     = 64;
    localparam int HOLD_CYCLES   = 300;   // length of the long receiver hold-off
    localparam int RANDOM_TICKS  = 1100;  // result-producing ticks in the random part
    localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write

    // The one register index that the block does not decode
    localparam logic [erstep_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                         pulse;
        logic [erstep_pkg::POS_W-1:0] position;
    } t_beat;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    // Block ports; every input starts at a known value
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_stall;
    logic                         i_tick      = 1'b0;
    logic                         o_valid;
    logic                         i_stall     = 1'b0;
    logic                         o_pulse;
    logic [erstep_pkg::POS_W-1:0] o_step_position;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [erstep_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [erstep_pkg::CFG_W-1:0] i_cfg_data  = '0;

    // Rhythm model: register copies and sequencer state
    logic [erstep_pkg::CFG_W-1:0] cfg_steps     = erstep_pkg::STEPS_RESET;
    logic [erstep_pkg::CFG_W-1:0] cfg_density   = erstep_pkg::DENSITY_RESET;
    logic [erstep_pkg::CFG_W-1:0] cfg_rotation  = erstep_pkg::ROTATION_RESET;
    logic [erstep_pkg::POS_W-1:0] model_counter = '0;
    logic [63:0]                  model_pattern = '0;

    // Beats predicted at tick transfer, waiting for their result transfer
    t_beat pending_beats[$];
    int    mismatches = 0;

    // Sender pacing and receiver hold-off handshake between processes
    int unsigned burst_left = 0;
    logic        bursty     = 1'b0;
    int unsigned ticks_sent = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    t_stall_mode stall_mode    = STALL_NONE;

    euclidean_rhythm_step_generator #(
        .MAX_STEPS(MAX_STEPS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_tick         (i_tick),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pulse        (o_pulse),
        .o_step_position(o_step_position),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Rhythm model
    // ------------------------------------------------------------------

    // Zero steps act as one, anything above the maximum acts as the maximum
    function automatic int unsigned effective_steps();
        if (cfg_steps == 0) return 1;
        if (cfg_steps > MAX_STEPS) return MAX_STEPS;
        return int'(cfg_steps);
    endfunction

    function automatic int unsigned clip_to_steps(logic [erstep_pkg::CFG_W-1:0] v);
        int unsigned n;
        n = effective_steps();
        return (v > n) ? n : int'(v);
    endfunction

    // Place pattern b (lb bits) above pattern a (la bits)
    function automatic logic [63:0] append_bits(logic [63:0] a, int unsigned la,
                                                logic [63:0] b, int unsigned lb);
        logic [63:0] masked;
        if (la >= 64 || lb == 0) return a;
        masked = (lb >= 64) ? b : (b & ((64'd1 << lb) - 64'd1));
        return a | (masked << la);
    endfunction

    function automatic logic [63:0] bjorklund_pattern(int unsigned n, int unsigned k);
        logic [63:0] head_bits, tail_bits, merged, result;
        int unsigned head_len, tail_len, merged_len, heads, tails, old_heads, len;
        head_bits = 64'd1;
        tail_bits = 64'd0;
        head_len  = 1;
        tail_len  = 1;
        heads     = k;
        tails     = n - k;
        result    = '0;
        len       = 0;
        // Fold tails into heads until at most one tail remains or no heads are left
        while (tails > 1 && heads != 0) begin
            merged     = append_bits(head_bits, head_len, tail_bits, tail_len);
            merged_len = head_len + tail_len;
            if (heads < tails) begin
                tails = tails - heads;
            end else begin
                old_heads = heads;
                tail_bits = head_bits;
                tail_len  = head_len;
                heads     = tails;
                tails     = old_heads - tails;
            end
            head_bits = merged;
            head_len  = merged_len;
        end
        for (int i = 0; i < heads && len < 64; i++) begin
            result = append_bits(result, len, head_bits, head_len);
            len += head_len;
        end
        for (int i = 0; i < tails && len < 64; i++) begin
            result = append_bits(result, len, tail_bits, tail_len);
            len += tail_len;
        end
        return result;
    endfunction

    task automatic rebuild_pattern();
        model_pattern = bjorklund_pattern(effective_steps(), clip_to_steps(cfg_density));
    endtask

    task automatic apply_reg_write(logic [erstep_pkg::IDX_W-1:0] idx,
                                   logic [erstep_pkg::CFG_W-1:0] data);
        case (idx)
            erstep_pkg::CFG_STEPS: begin
                cfg_steps     = data;
                model_counter = '0;
                rebuild_pattern();
            end
            erstep_pkg::CFG_DENSITY: begin
                cfg_density = data;
                rebuild_pattern();
            end
            erstep_pkg::CFG_ROTATION: cfg_rotation = data;
            default: ;
        endcase
    endtask

    // Read the step under the counter, queue the beat, then advance and wrap
    task automatic record_beat();
        int unsigned n, pos;
        t_beat       beat;
        n             = effective_steps();
        pos           = (clip_to_steps(cfg_rotation) + model_counter) % n;
        beat.pulse    = model_pattern[pos];
        beat.position = pos[erstep_pkg::POS_W-1:0];
        pending_beats.push_back(beat);
        if (int'(model_counter) + 1 >= n) model_counter = '0;
        else model_counter = model_counter + 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every result transfer with the oldest beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pulse    = o_pulse;
            got.position = o_step_position;
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pulse=%0b position=%0d",
                             got.pulse, got.position);
            end else begin
                want = pending_beats.pop_front();
                if (got.pulse !== want.pulse || got.position !== want.position) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected pulse=%0b position=%0d, ",
                                  "got pulse=%0b position=%0d"},
                                 want.pulse, want.position, got.pulse, got.position);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        // Pick up a new hold-off request and count it down here
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            // Pick a new stall density whenever the current mode runs out, quiet stretches included
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
                default:     i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one tick and hold it until the transfer; valid stays high afterwards
    // so that a following tick in the same burst goes out back to back.
    task automatic offer_tick(logic tick);
        if (burst_left == 0) begin
            if (bursty) begin
                i_valid <= 1'b0;
                i_tick  <= 1'($urandom);
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_tick  <= tick;
        do @(posedge i_clk); while (o_stall);
        if (tick) begin
            record_beat();
            ticks_sent++;
        end
        burst_left--;
    endtask

    // Drop valid, drain every expected beat, then let dropped ticks clear
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register transfer; waits out any pattern rebuild through ready
    task automatic write_reg(logic [erstep_pkg::IDX_W-1:0] idx,
                             logic [erstep_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [erstep_pkg::CFG_W-1:0] steps_val,
                             logic [erstep_pkg::CFG_W-1:0] density_val,
                             logic [erstep_pkg::CFG_W-1:0] rotation_val);
        settle();
        write_reg(erstep_pkg::CFG_STEPS, steps_val);
        write_reg(erstep_pkg::CFG_DENSITY, density_val);
        write_reg(erstep_pkg::CFG_ROTATION, rotation_val);
    endtask

    function automatic logic [erstep_pkg::CFG_W-1:0] random_reg_value(
        logic [erstep_pkg::IDX_W-1:0] idx);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (idx == erstep_pkg::CFG_STEPS) begin
            // Mostly legal lengths, some zero, full scale and above range
            if (pick == 0) return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd127;
            if (pick == 1) return erstep_pkg::CFG_W'($urandom_range(65, 127));
            return erstep_pkg::CFG_W'($urandom_range(1, MAX_STEPS));
        end
        if (pick < 2) return erstep_pkg::CFG_W'($urandom_range(0, 127));
        return erstep_pkg::CFG_W'($urandom_range(0, MAX_STEPS));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 16 steps, no pulses, counter from zero; a zero tick is dropped
    task automatic test_reset_state();
        bursty = 1'b0;
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b1);
    endtask

    // Extremes of every register and the saturation cases
    task automatic test_extremes();
        bursty = 1'b1;
        // Single step, single pulse: every tick hits step zero
        configure(7'd1, 7'd1, 7'd0);
        offer_tick(1'b1);
        offer_tick(1'b1);
        // Full cycle, full density, rotation equal to steps acts as zero
        configure(7'd64, 7'd64, 7'd64);
        offer_tick(1'b1);
        offer_tick(1'b1);
        // Zero steps act as one; density and rotation saturate
        configure(7'd0, 7'd127, 7'd127);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b1);
        // Steps above range act as the maximum
        configure(7'd127, 7'd5, 7'd127);
        offer_tick(1'b1);
        offer_tick(1'b1);
        // Small rhythm, rotated, up to its last step
        configure(7'd5, 7'd3, 7'd2);
        offer_tick(1'b1);
        offer_tick(1'b1);
        offer_tick(1'b1);
        // Undecoded index leaves everything alone
        settle();
        write_reg(CFG_UNUSED, 7'h7F);
        offer_tick(1'b1);
        // Rotation alone keeps the counter running
        settle();
        write_reg(erstep_pkg::CFG_ROTATION, 7'd4);
        offer_tick(1'b1);
        // No pulses at full length, rotation one short of the end
        configure(7'd64, 7'd0, 7'd63);
        offer_tick(1'b1);
        offer_tick(1'b1);
        configure(7'd2, 7'd1, 7'd1);
        offer_tick(1'b1);
        offer_tick(1'b1);
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming,
    // so the block fills up and stalls its input
    task automatic test_backpressure();
        configure(7'd7, 7'd3, 7'd1);
        bursty = 1'b0;
        hold_requests++;
        repeat (60) offer_tick(1'b1);
    endtask

    // Random settings written from a random starting index, then runs of mostly real ticks
    task automatic test_random_rhythms();
        int unsigned                  start, run;
        logic [erstep_pkg::IDX_W-1:0] idx;
        logic                         pick;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS) begin
            settle();
            idx = erstep_pkg::IDX_W'($urandom);
            for (int j = 0; j < 4; j++) begin
                if (idx == CFG_UNUSED) pick = ($urandom_range(0, 3) == 0);
                else pick = ($urandom_range(0, 3) != 0);
                if (pick) write_reg(idx, random_reg_value(idx));
                idx = idx + 1'b1;
            end
            bursty = ($urandom_range(0, 9) < 7);
            run    = $urandom_range(8, 70);
            repeat (run) offer_tick($urandom_range(0, 9) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rebuild_pattern();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_extremes();
        test_backpressure();
        test_random_rhythms();
        // Drain the last beats and let the block run quiet before the verdict
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// File: euclidean_rhythm_step_generator.f
design/erstep_pkg.sv
design/erstep_ctrl.sv
design/erstep_datapath.sv
design/euclidean_rhythm_step_generator.sv
tb/tb.sv
